@@ src/rgbe_rle_scanline_decoder_macros.svh @@
// Assertion macros shared by the checker of the RGBE scanline decoder.
// No dependencies.
`ifndef RGBE_RLE_SCANLINE_DECODER_MACROS_SVH
`define RGBE_RLE_SCANLINE_DECODER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ src/rrd_pkg.sv @@
// Package of the RGBE scanline decoder: widths, codes and the pixel converter.
// No dependencies.
package rrd_pkg;
   localparam int MAX_WIDTH_DEF = 4096;
   localparam int RUN_BASE = 128;
   localparam int EXP_BIAS = 136;
   localparam int MAX_ROWS = 16384;

   localparam logic [1:0] CMD_DATA    = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_LINE     = 3'd1;
   localparam logic [2:0] ST_IMAGE    = 3'd2;
   localparam logic [2:0] ST_READ     = 3'd3;
   localparam logic [2:0] ST_BAD_HDR  = 3'd4;
   localparam logic [2:0] ST_ZERO_CNT = 3'd5;
   localparam logic [2:0] ST_OVERRUN  = 3'd6;
   localparam logic [2:0] ST_IGNORED  = 3'd7;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] red_bits;
      logic [31:0] green_bits;
      logic [31:0] blue_bits;
      logic [13:0] row_number;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data_byte;
      logic [11:0] pixel_index;
   } req_type;

   // Converts one mantissa byte and the shared exponent into single bits.
   function automatic logic [31:0] rgbe_to_bits(input logic [7:0] m, input logic [7:0] e);
      logic [2:0] p;
      logic [8:0] be;
      logic [31:0] r;
      p = 3'd0;
      r = 32'd0;
      for (int i = 0; i < 8; i++) if (m[i]) p = 3'(i);
      be = 9'(p) + 9'(e);
      if (m == 8'd0 || e == 8'd0) r = 32'd0;
      else if (be >= 9'd10)
         r = {1'b0, 8'(be - 9'd9), 23'((32'(m) << (5'd23 - 5'(p))) & 32'h7FFFFF)};
      else r = 32'(m) << (6'(e) + 6'd13);
      return r;
   endfunction
endpackage

@@ src/rrd_if.sv @@
// Valid/ready channel interfaces of the RGBE scanline decoder.
// Depends on rrd_pkg.
interface rrd_req_if;
   logic valid;
   logic ready;
   rrd_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rrd_rsp_if;
   logic valid;
   logic ready;
   rrd_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/rrd_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module rrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

@@ src/rgbe_rle_scanline_decoder.sv @@
// Top level of the RGBE scanline decoder: sequencer, line store and output register.
// Depends on rrd_pkg, rrd_if and rrd_ram.
//
// The block takes one request beat at a time and answers each with exactly one
// response beat. A data byte of a header, a count or a literal is handled in the
// fill state and then goes to the response register; a run byte writes its value
// into the line store one entry per cycle. A pixel read walks the single port of
// the line store four times (red, green, blue, exponent) and then converts.
// Restart answers at once and keeps the line store. The store is 4*MAX_WIDTH
// bytes, channel c of column x at c*image_width+x, and needs no clearing after
// reset. Request ready is low while an item is being worked on and while its
// response still waits.
module rgbe_rle_scanline_decoder #(
   parameter int MAX_WIDTH = rrd_pkg::MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rrd_req_if.sink     req,
   rrd_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata
);
   localparam int DEPTH = 4 * MAX_WIDTH;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = 17;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_COUNT  = 3'd1;
   localparam logic [2:0] PH_RUN    = 3'd2;
   localparam logic [2:0] PH_LIT    = 3'd3;
   localparam logic [2:0] PH_ERROR  = 3'd4;

   localparam logic [2:0] SQ_IDLE = 3'd0;
   localparam logic [2:0] SQ_FILL = 3'd1;
   localparam logic [2:0] SQ_RD   = 3'd2;
   localparam logic [2:0] SQ_CONV = 3'd3;
   localparam logic [2:0] SQ_OUT  = 3'd4;

   logic [12:0] width_ff;
   logic [14:0] height_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  hpos_ff, hpos_in;
   logic [7:0]  whigh_ff, whigh_in;
   logic [1:0]  chan_ff, chan_in;
   logic [12:0] col_ff, col_in;
   logic [6:0]  left_ff, left_in;
   logic [13:0] row_ff, row_in;
   logic [2:0]  seq_ff, seq_in;
   logic [7:0]  byte_ff, byte_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [2:0]  rdk_ff, rdk_in;
   logic [11:0] px_ff, px_in;
   logic        rdok_ff, rdok_in;
   logic [7:0]  m_ff [3];
   logic [7:0]  m_in [3];
   rrd_pkg::rsp_type out_ff, out_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_rdata;
   logic [CW-1:0] addr_full;

   logic        width_ok;
   logic [14:0] eff_h;
   logic [7:0]  n;
   logic [14:0] row_p1;

   rrd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(byte_ff), .rdata(ram_rdata)
   );

   assign width_ok = (width_ff >= 13'd8) && (32'(width_ff) <= MAX_WIDTH);
   assign eff_h = (height_ff == 15'd0 || 32'(height_ff) > rrd_pkg::MAX_ROWS)
                  ? 15'(rrd_pkg::MAX_ROWS) : height_ff;
   assign req.ready = (seq_ff == SQ_IDLE);
   assign rsp.valid = (seq_ff == SQ_OUT);
   assign rsp.payload = out_ff;
   // One bit wider than the row counter so that the last row of a full-height
   // image does not wrap before the compare.
   assign row_p1 = 15'(row_ff) + 15'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd8;
         height_ff <= 15'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            rrd_pkg::CSR_WIDTH:  width_ff <= csr_wdata[12:0];
            rrd_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff; hpos_in = hpos_ff; whigh_in = whigh_ff; chan_in = chan_ff;
      col_in = col_ff; left_in = left_ff; row_in = row_ff; seq_in = seq_ff;
      byte_in = byte_ff; cnt_in = cnt_ff; rdk_in = rdk_ff; px_in = px_ff;
      rdok_in = rdok_ff; m_in = m_ff; out_in = out_ff;
      ram_we = 1'b0;
      n = 8'd0;
      addr_full = CW'(chan_ff) * CW'(width_ff) + CW'(col_ff) + CW'(cnt_ff);
      unique case (seq_ff)
         SQ_IDLE: begin
            if (req.valid) begin
               out_in = '0;
               out_in.row_number = row_ff;
               byte_in = req.payload.data_byte;
               seq_in = SQ_OUT;
               priority case (req.payload.cmd)
                  rrd_pkg::CMD_DATA: begin
                     out_in.status = rrd_pkg::ST_OK;
                     seq_in = SQ_FILL;
                     cnt_in = 7'd0;
                  end
                  rrd_pkg::CMD_READ: begin
                     out_in.status = rrd_pkg::ST_READ;
                     px_in = req.payload.pixel_index;
                     rdok_in = width_ok && (13'(req.payload.pixel_index) < width_ff);
                     rdk_in = 3'd0;
                     seq_in = SQ_RD;
                  end
                  rrd_pkg::CMD_RESTART: begin
                     phase_in = PH_HEADER; hpos_in = 2'd0; whigh_in = 8'd0; chan_in = 2'd0;
                     col_in = 13'd0; left_in = 7'd0; row_in = 14'd0;
                     out_in.row_number = 14'd0;
                  end
                  default: ;
               endcase
            end
         end
         SQ_FILL: begin
            seq_in = SQ_OUT;
            unique case (phase_ff)
               PH_HEADER: begin
                  if (hpos_ff != 2'd3 && hpos_ff != 2'd2) begin
                     if (byte_ff != 8'd2) begin
                        phase_in = PH_ERROR; out_in.status = rrd_pkg::ST_BAD_HDR;
                     end else hpos_in = hpos_ff + 2'd1;
                  end else if (hpos_ff == 2'd2) begin
                     whigh_in = byte_ff; hpos_in = 2'd3;
                  end else if (!width_ok || {whigh_ff, byte_ff} != {3'd0, width_ff}) begin
                     phase_in = PH_ERROR; out_in.status = rrd_pkg::ST_BAD_HDR;
                  end else begin
                     hpos_in = 2'd0; chan_in = 2'd0; col_in = 13'd0; phase_in = PH_COUNT;
                  end
               end
               PH_COUNT: begin
                  n = (byte_ff > 8'(rrd_pkg::RUN_BASE)) ? byte_ff - 8'(rrd_pkg::RUN_BASE)
                                                         : byte_ff;
                  if (byte_ff == 8'd0) begin
                     phase_in = PH_ERROR; out_in.status = rrd_pkg::ST_ZERO_CNT;
                  end else if (!width_ok || col_ff >= width_ff ||
                               13'(n) > width_ff - col_ff) begin
                     phase_in = PH_ERROR; out_in.status = rrd_pkg::ST_OVERRUN;
                  end else if (byte_ff > 8'(rrd_pkg::RUN_BASE)) begin
                     left_in = n[6:0]; phase_in = PH_RUN;
                  end else begin
                     left_in = 7'(n - 8'd1); phase_in = PH_LIT;
                  end
               end
               PH_RUN, PH_LIT: begin
                  ram_we = addr_full < CW'(DEPTH);
                  if (phase_ff == PH_RUN && cnt_ff + 7'd1 < left_ff) begin
                     cnt_in = cnt_ff + 7'd1;
                     seq_in = SQ_FILL;
                  end else if (phase_ff == PH_LIT && left_ff != 7'd0) begin
                     left_in = left_ff - 7'd1;
                     col_in = col_ff + 13'd1;
                  end else begin
                     // Column advance at the end of a run or of a literal group.
                     col_in = col_ff + 13'(phase_ff == PH_RUN ? left_ff : 7'd1);
                     left_in = 7'd0;
                     phase_in = PH_COUNT;
                     if (col_in >= width_ff) begin
                        col_in = 13'd0;
                        if (chan_ff != 2'd3) chan_in = chan_ff + 2'd1;
                        else begin
                           chan_in = 2'd0; phase_in = PH_HEADER; hpos_in = 2'd0;
                           if (row_p1 >= eff_h) begin
                              row_in = 14'd0; out_in.status = rrd_pkg::ST_IMAGE;
                           end else begin
                              row_in = row_p1[13:0]; out_in.status = rrd_pkg::ST_LINE;
                           end
                        end
                     end
                  end
               end
               default: out_in.status = rrd_pkg::ST_IGNORED;
            endcase
         end
         SQ_RD: begin
            addr_full = CW'(rdk_ff) * CW'(width_ff) + CW'(px_ff);
            if (rdk_ff != 3'd0) m_in[2'(rdk_ff - 3'd1)] = ram_rdata;
            rdk_in = rdk_ff + 3'd1;
            if (rdk_ff == 3'd3) seq_in = SQ_CONV;
         end
         SQ_CONV: begin
            if (rdok_ff) begin
               out_in.red_bits = rrd_pkg::rgbe_to_bits(m_ff[0], ram_rdata);
               out_in.green_bits = rrd_pkg::rgbe_to_bits(m_ff[1], ram_rdata);
               out_in.blue_bits = rrd_pkg::rgbe_to_bits(m_ff[2], ram_rdata);
            end
            seq_in = SQ_OUT;
         end
         SQ_OUT: if (rsp.ready) seq_in = SQ_IDLE;
         default: seq_in = SQ_IDLE;
      endcase
      ram_addr = addr_full[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; hpos_ff <= 2'd0; whigh_ff <= 8'd0; chan_ff <= 2'd0;
         col_ff <= 13'd0; left_ff <= 7'd0; row_ff <= 14'd0; seq_ff <= SQ_IDLE;
      end else begin
         phase_ff <= phase_in; hpos_ff <= hpos_in; whigh_ff <= whigh_in; chan_ff <= chan_in;
         col_ff <= col_in; left_ff <= left_in; row_ff <= row_in; seq_ff <= seq_in;
      end
      byte_ff <= byte_in; cnt_ff <= cnt_in; rdk_ff <= rdk_in; px_ff <= px_in;
      rdok_ff <= rdok_in; m_ff <= m_in; out_ff <= out_in;
   end
endmodule

@@ src/rrd_checker.sv @@
// Port-level checker of the RGBE scanline decoder, bound to the top level.
// Depends on rrd_pkg and the macro header.
`include "rgbe_rle_scanline_decoder_macros.svh"
module rrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_red
);
   // One item at a time: no new request while a response waits.
   `RRD_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // After a response beat the block is ready again.
   `RRD_ASSERT_NEXT(a_ready_after, clock, reset, rsp_valid && rsp_ready, req_ready)
   // Red color bits appear only in read responses.
   `RRD_ASSERT_IMPL(a_color_read, clock, reset,
      rsp_valid && rsp_status != rrd_pkg::ST_READ, rsp_red == 32'd0)
   // Accepting a request drops ready in the next cycle.
   `RRD_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind rgbe_rle_scanline_decoder rrd_checker u_rrd_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.payload.status),
   .rsp_red(rsp.payload.red_bits)
);
